// ----- hdl/mbrpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mbrpt_pkg;

  // Sector geometry and partition table layout.
  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned TABLE_SLOTS  = 4;
  localparam int unsigned SLOT_BYTES   = 16;
  localparam int unsigned TABLE_BASE   = 446;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned SLOT_W       = 2;
  localparam int unsigned USED_W       = 3;

  localparam logic [POS_W-1:0] POS_TABLE_FIRST = POS_W'(TABLE_BASE);
  localparam logic [POS_W-1:0] POS_TABLE_END   = POS_W'(TABLE_BASE + TABLE_SLOTS * SLOT_BYTES);
  localparam logic [POS_W-1:0] POS_SIG_LOW     = POS_W'(SECTOR_BYTES - 2);
  localparam logic [POS_W-1:0] POS_SIG_HIGH    = POS_W'(SECTOR_BYTES - 1);
  localparam logic [POS_W-1:0] POS_DONE        = POS_W'(SECTOR_BYTES);

  // Byte values with a fixed meaning.
  localparam logic [7:0] SIG_LOW_BYTE  = 8'h55;
  localparam logic [7:0] SIG_HIGH_BYTE = 8'hAA;
  localparam logic [7:0] STATUS_BOOT   = 8'h80;
  localparam logic [7:0] TYPE_EMPTY    = 8'h00;
  localparam logic [7:0] TYPE_FAT32    = 8'h0B;
  localparam logic [7:0] TYPE_FAT32LBA = 8'h0C;
  localparam logic [7:0] TYPE_LINUX    = 8'h83;
  localparam logic [7:0] TYPE_EFI      = 8'hEF;

  // Filesystem class codes.
  typedef enum logic [1:0] {
    FS_FAT32   = 2'd0,
    FS_LINUX   = 2'd1,
    FS_EFI     = 2'd2,
    FS_UNKNOWN = 2'd3
  } fs_class_t;

  // One stored table entry: status, type, start sector and length.
  localparam int unsigned ENTRY_W = 80;
  typedef logic [ENTRY_W-1:0] entry_t;

  function automatic fs_class_t classify(input logic [7:0] ptype);
    fs_class_t cls;
    if (ptype == TYPE_FAT32 || ptype == TYPE_FAT32LBA) cls = FS_FAT32;
    else if (ptype == TYPE_LINUX) cls = FS_LINUX;
    else if (ptype == TYPE_EFI) cls = FS_EFI;
    else cls = FS_UNKNOWN;
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mbr_partition_table_parser_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// MBR partition table parser.
// The input channel (in_valid/in_ready) carries one boot sector byte per
// transfer; in_sector_start marks byte 0 and restarts the byte position.
// The status, type, start and length bytes of each table slot are written
// into a four-entry memory as they pass by.
// Bytes are taken one per cycle while the block is collecting a sector.
// After byte 511 the block stops taking input and scans the four slots,
// each with a memory read state and then an evaluate state, and then
// issues the summary.
// The result channel (out_valid/out_ready) has one output register; the
// scan holds while it has a result for that register and the register is
// full and not being taken, so a stalled receiver simply stretches the
// scan. Bytes beyond 511 are taken and ignored until the next sector start.
// Reset clears the byte position, the scan state and the output valid.
module mbr_partition_table_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_sector_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_is_summary,
  output logic [1:0]       out_slot_index,
  output logic [7:0]       out_part_type,
  output logic             out_bootable,
  output logic [1:0]       out_fs_class,
  output logic [31:0]      out_start_lba,
  output logic [31:0]      out_sector_count,
  output logic             out_signature_ok,
  output logic             out_any_entry_marked,
  output logic [2:0]       out_used_entries,
  output logic             out_last
);

  typedef enum logic [1:0] {
    ST_IN,
    ST_RD,
    ST_EVAL,
    ST_SUM
  } state_t;

  state_t state_r;

  logic [mbrpt_pkg::POS_W-1:0]  pos_r;
  logic [7:0]                   sig_low_r;
  logic                         sig_ok_r;
  logic                         marked_r;
  logic [mbrpt_pkg::USED_W-1:0] used_r;
  logic [mbrpt_pkg::SLOT_W-1:0] slot_r;

  mbrpt_pkg::entry_t entry_mem [mbrpt_pkg::TABLE_SLOTS];
  mbrpt_pkg::entry_t rd_data_r;

  // Output register.
  logic        out_valid_r;
  logic        out_is_summary_r;
  logic [1:0]  out_slot_index_r;
  logic [7:0]  out_part_type_r;
  logic        out_bootable_r;
  logic [1:0]  out_fs_class_r;
  logic [31:0] out_start_lba_r;
  logic [31:0] out_sector_count_r;
  logic        out_signature_ok_r;
  logic        out_any_entry_marked_r;
  logic [2:0]  out_used_entries_r;
  logic        out_last_r;

  logic                        in_xfer;
  logic [mbrpt_pkg::POS_W-1:0] pos_cur;
  logic                        pos_live;
  logic [mbrpt_pkg::POS_W-1:0] tbl_off;
  logic [mbrpt_pkg::SLOT_W-1:0] wr_slot;
  logic [3:0]                  wr_field;
  logic [3:0]                  wr_lane;
  logic                        wr_field_kept;
  logic                        wr_en;
  logic                        out_free;
  logic [7:0]                  rd_status;
  logic [7:0]                  rd_type;
  logic                        rd_emit;
  logic                        eval_adv;
  logic                        out_load;

  assign in_ready = (state_r == ST_IN);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Position of the byte in this transfer; a sector start restarts it.
  assign pos_cur  = in_sector_start ? '0 : pos_r;
  assign pos_live = (pos_cur < mbrpt_pkg::POS_DONE);

  // Decode the table slot and the byte within the slot.
  assign tbl_off  = pos_cur - mbrpt_pkg::POS_TABLE_FIRST;
  assign wr_slot  = tbl_off[5:4];
  assign wr_field = tbl_off[3:0];

  // Map the slot byte to a byte lane of the stored entry.
  always_comb begin
    wr_lane       = '0;
    wr_field_kept = 1'b0;
    if (wr_field == 4'd0) begin
      wr_lane       = 4'd0;
      wr_field_kept = 1'b1;
    end else if (wr_field == 4'd4) begin
      wr_lane       = 4'd1;
      wr_field_kept = 1'b1;
    end else if (wr_field >= 4'd8) begin
      wr_lane       = wr_field - 4'd6;
      wr_field_kept = 1'b1;
    end
  end

  assign wr_en = in_xfer && pos_live && wr_field_kept &&
                 (pos_cur >= mbrpt_pkg::POS_TABLE_FIRST) &&
                 (pos_cur < mbrpt_pkg::POS_TABLE_END);

  // Entry memory: byte-lane writes while collecting, one registered read per slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_slot][{wr_lane, 3'b000} +: 8] <= in_data_byte;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= entry_mem[slot_r];
    end
  end

  assign rd_status = rd_data_r[7:0];
  assign rd_type   = rd_data_r[15:8];
  assign rd_emit   = sig_ok_r && (rd_type != mbrpt_pkg::TYPE_EMPTY);
  assign eval_adv  = !rd_emit || out_free;

  // The output register is loaded with a new result in this cycle.
  assign out_load  = ((state_r == ST_EVAL) && eval_adv && rd_emit) ||
                     ((state_r == ST_SUM) && out_free);

  // Sequencer: byte collection, slot scan and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IN: begin
          if (in_xfer) begin
            if (pos_live) begin
              pos_r <= pos_cur + 1'b1;
              if (pos_cur == mbrpt_pkg::POS_SIG_LOW) begin
                sig_low_r <= in_data_byte;
              end
              if (pos_cur == mbrpt_pkg::POS_SIG_HIGH) begin
                sig_ok_r <= (sig_low_r == mbrpt_pkg::SIG_LOW_BYTE) &&
                            (in_data_byte == mbrpt_pkg::SIG_HIGH_BYTE);
                marked_r <= 1'b0;
                used_r   <= '0;
                slot_r   <= '0;
                state_r  <= ST_RD;
              end
            end else begin
              pos_r <= pos_cur;
            end
          end
        end
        ST_RD: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (eval_adv) begin
            if ((rd_status != 8'h00) || (rd_type != mbrpt_pkg::TYPE_EMPTY)) begin
              marked_r <= 1'b1;
            end
            if (rd_emit) begin
              used_r                 <= used_r + 1'b1;
              out_valid_r            <= 1'b1;
              out_is_summary_r       <= 1'b0;
              out_slot_index_r       <= slot_r;
              out_part_type_r        <= rd_type;
              out_bootable_r         <= (rd_status == mbrpt_pkg::STATUS_BOOT);
              out_fs_class_r         <= mbrpt_pkg::classify(rd_type);
              out_start_lba_r        <= rd_data_r[47:16];
              out_sector_count_r     <= rd_data_r[79:48];
              out_signature_ok_r     <= 1'b1;
              out_any_entry_marked_r <= 1'b0;
              out_used_entries_r     <= '0;
              out_last_r             <= 1'b0;
            end
            if (slot_r == mbrpt_pkg::SLOT_W'(mbrpt_pkg::TABLE_SLOTS - 1)) begin
              state_r <= ST_SUM;
            end else begin
              slot_r  <= slot_r + 1'b1;
              state_r <= ST_RD;
            end
          end
        end
        ST_SUM: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_is_summary_r       <= 1'b1;
            out_slot_index_r       <= '0;
            out_part_type_r        <= '0;
            out_bootable_r         <= 1'b0;
            out_fs_class_r         <= '0;
            out_start_lba_r        <= '0;
            out_sector_count_r     <= '0;
            out_signature_ok_r     <= sig_ok_r;
            out_any_entry_marked_r <= marked_r;
            out_used_entries_r     <= used_r;
            out_last_r             <= 1'b1;
            state_r                <= ST_IN;
          end
        end
        default: begin
          state_r <= ST_IN;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_is_summary       = out_is_summary_r;
  assign out_slot_index       = out_slot_index_r;
  assign out_part_type        = out_part_type_r;
  assign out_bootable         = out_bootable_r;
  assign out_fs_class         = out_fs_class_r;
  assign out_start_lba        = out_start_lba_r;
  assign out_sector_count     = out_sector_count_r;
  assign out_signature_ok     = out_signature_ok_r;
  assign out_any_entry_marked = out_any_entry_marked_r;
  assign out_used_entries     = out_used_entries_r;
  assign out_last             = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/mbrpt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbrpt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_data_byte,
  input wire logic        in_sector_start,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_is_summary,
  input wire logic [1:0]  out_slot_index,
  input wire logic [7:0]  out_part_type,
  input wire logic        out_bootable,
  input wire logic [1:0]  out_fs_class,
  input wire logic [31:0] out_start_lba,
  input wire logic [31:0] out_sector_count,
  input wire logic        out_signature_ok,
  input wire logic        out_any_entry_marked,
  input wire logic [2:0]  out_used_entries,
  input wire logic        out_last
);

  // A stalled result keeps its contents until the transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_summary) &&
      $stable(out_slot_index) && $stable(out_part_type) && $stable(out_bootable) &&
      $stable(out_fs_class) && $stable(out_start_lba) && $stable(out_sector_count) &&
      $stable(out_signature_ok) && $stable(out_any_entry_marked) &&
      $stable(out_used_entries) && $stable(out_last))
    else $error("stalled result changed");

  // A waiting byte stays offered, unchanged, until the transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) &&
      $stable(in_sector_start))
    else $error("waiting input byte changed");

  // Only the summary closes a run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_is_summary))
    else $error("last flag disagrees with summary flag");

  // Entry results appear only for a valid signature and carry typed slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_summary |-> out_signature_ok && (out_part_type != 8'h00))
    else $error("entry result without signature or type");

  // A failed signature reports no used entries, and the count never exceeds four.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_summary |->
      (out_used_entries <= 3'd4) && (out_signature_ok || (out_used_entries == 3'd0)))
    else $error("summary used count out of range");

endmodule

bind mbr_partition_table_parser_unit mbrpt_checker u_mbrpt_checker (.*);

`default_nettype wire

// ----- bench/tb_mbr_partition_table_parser_unit.sv -----
`timescale 1ns / 1ps

module tb_mbr_partition_table_parser_unit;

  // One result as it leaves the block.
  typedef struct packed {
    logic        is_summary;
    logic [1:0]  slot;
    logic [7:0]  ptype;
    logic        boot;
    logic [1:0]  cls;
    logic [31:0] lba;
    logic [31:0] cnt;
    logic        sig;
    logic        marked;
    logic [2:0]  used;
    logic        last;
  } parse_result_t;

  // Recipe for one boot sector. Slot i sits in byte i of st and ty and in
  // word i of lba and cnt. Rows marked hand_checked carry their expected
  // summary, and entries for slots 0 up to exp_used-1, typed in directly.
  typedef struct {
    bit          lead;
    logic [31:0] st;
    logic [31:0] ty;
    logic [127:0] lba;
    logic [127:0] cnt;
    logic [7:0]  lo;
    logic [7:0]  hi;
    int          restart;
    int          extra;
    bit          hand_checked;
    bit          exp_sig;
    bit          exp_marked;
    int          exp_used;
    bit          exp_boot;
    mbrpt_pkg::fs_class_t exp_cls;
  } sector_plan_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_sector_start;
  logic        out_valid;
  logic        out_ready;
  logic        out_is_summary;
  logic [1:0]  out_slot_index;
  logic [7:0]  out_part_type;
  logic        out_bootable;
  logic [1:0]  out_fs_class;
  logic [31:0] out_start_lba;
  logic [31:0] out_sector_count;
  logic        out_signature_ok;
  logic        out_any_entry_marked;
  logic [2:0]  out_used_entries;
  logic        out_last;

  // Predictor state: position in the sector and the captured table.
  int          sector_pos = 0;
  logic [7:0]  slot_status [4];
  logic [7:0]  slot_type [4];
  logic [31:0] slot_lba [4];
  logic [31:0] slot_len [4];
  logic [7:0]  sig_low;

  parse_result_t pending_results [$];
  sector_plan_t  directed_plans [$];
  bit            typed_sector = 1'b0;
  bit            steady = 1'b0;
  int            results_predicted = 0;
  int            mismatch_count = 0;

  mbr_partition_table_parser_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one expected result at the tail of the queue.
  task automatic expect_result(input parse_result_t r);
    pending_results = {pending_results, r};
  endtask

  // Append one sector recipe to the directed table.
  task automatic add_plan(input sector_plan_t p);
    directed_plans = {directed_plans, p};
  endtask

  function automatic mbrpt_pkg::fs_class_t fs_of_type(input logic [7:0] t);
    case (t)
      mbrpt_pkg::TYPE_FAT32, mbrpt_pkg::TYPE_FAT32LBA: return mbrpt_pkg::FS_FAT32;
      mbrpt_pkg::TYPE_LINUX:                           return mbrpt_pkg::FS_LINUX;
      mbrpt_pkg::TYPE_EFI:                             return mbrpt_pkg::FS_EFI;
      default:                                         return mbrpt_pkg::FS_UNKNOWN;
    endcase
  endfunction

  function automatic parse_result_t entry_result(input int slot, input logic [7:0] t,
                                                 input bit boot,
                                                 input mbrpt_pkg::fs_class_t cls,
                                                 input logic [31:0] lba,
                                                 input logic [31:0] cnt);
    parse_result_t r;
    r = '0;
    r.slot = 2'(slot);
    r.ptype = t;
    r.boot = boot;
    r.cls = cls;
    r.lba = lba;
    r.cnt = cnt;
    r.sig = 1'b1;
    return r;
  endfunction

  function automatic parse_result_t summary_result(input bit sig, input bit marked,
                                                   input int used);
    parse_result_t r;
    r = '0;
    r.is_summary = 1'b1;
    r.sig = sig;
    r.marked = marked;
    r.used = 3'(used);
    r.last = 1'b1;
    return r;
  endfunction

  function automatic sector_plan_t plan(input bit lead, input logic [31:0] st,
                                        input logic [31:0] ty, input logic [127:0] lba,
                                        input logic [127:0] cnt, input logic [7:0] lo,
                                        input logic [7:0] hi, input int restart,
                                        input int extra, input bit hand,
                                        input bit esig, input bit emark, input int eused,
                                        input bit eboot,
                                        input mbrpt_pkg::fs_class_t ecls);
    sector_plan_t p;
    p.lead = lead;
    p.st = st;
    p.ty = ty;
    p.lba = lba;
    p.cnt = cnt;
    p.lo = lo;
    p.hi = hi;
    p.restart = restart;
    p.extra = extra;
    p.hand_checked = hand;
    p.exp_sig = esig;
    p.exp_marked = emark;
    p.exp_used = eused;
    p.exp_boot = eboot;
    p.exp_cls = ecls;
    return p;
  endfunction

  // Random sector: mostly well formed, with some broken signatures,
  // restarts in mid-sector, trailing bytes and missing sector starts.
  function automatic sector_plan_t random_plan();
    sector_plan_t p;
    int r;
    p = plan(1'b1, '0, '0, {$urandom, $urandom, $urandom, $urandom},
             {$urandom, $urandom, $urandom, $urandom},
             mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
             0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN);
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 7);
      case (r)
        0, 1:    p.ty[8*i +: 8] = mbrpt_pkg::TYPE_EMPTY;
        2:       p.ty[8*i +: 8] = mbrpt_pkg::TYPE_FAT32;
        3:       p.ty[8*i +: 8] = mbrpt_pkg::TYPE_FAT32LBA;
        4:       p.ty[8*i +: 8] = mbrpt_pkg::TYPE_LINUX;
        5:       p.ty[8*i +: 8] = mbrpt_pkg::TYPE_EFI;
        default: p.ty[8*i +: 8] = 8'($urandom);
      endcase
      r = $urandom_range(0, 3);
      case (r)
        0:       p.st[8*i +: 8] = 8'h00;
        1:       p.st[8*i +: 8] = mbrpt_pkg::STATUS_BOOT;
        default: p.st[8*i +: 8] = 8'($urandom);
      endcase
    end
    r = $urandom_range(0, 9);
    if (r == 0) p.lo = 8'($urandom);
    else if (r == 1) p.hi = 8'($urandom);
    if ($urandom_range(0, 9) == 0) p.restart = $urandom_range(1, mbrpt_pkg::SECTOR_BYTES - 1);
    if ($urandom_range(0, 6) == 0) p.extra = $urandom_range(1, 8);
    if ($urandom_range(0, 19) == 0) p.lead = 1'b0;
    return p;
  endfunction

  // Idle cycles before a byte: mostly none or short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Predictor: advance the sector by one accepted byte and queue the
  // results that byte 511 produces.
  task automatic track_byte(input logic [7:0] d, input logic s);
    int p;
    int off;
    int slot;
    int fld;
    bit sig;
    bit marked;
    int used;
    begin
      if (s) sector_pos = 0;
      if (sector_pos < mbrpt_pkg::SECTOR_BYTES) begin
        p = sector_pos;
        sector_pos = sector_pos + 1;
        if (p >= mbrpt_pkg::TABLE_BASE &&
            p < mbrpt_pkg::TABLE_BASE + mbrpt_pkg::TABLE_SLOTS * mbrpt_pkg::SLOT_BYTES) begin
          off = p - mbrpt_pkg::TABLE_BASE;
          slot = off / mbrpt_pkg::SLOT_BYTES;
          fld = off % mbrpt_pkg::SLOT_BYTES;
          if (fld == 0) slot_status[slot] = d;
          else if (fld == 4) slot_type[slot] = d;
          else if (fld >= 8 && fld < 12) slot_lba[slot][8*(fld-8) +: 8] = d;
          else if (fld >= 12) slot_len[slot][8*(fld-12) +: 8] = d;
        end else if (p == mbrpt_pkg::SECTOR_BYTES - 2) begin
          sig_low = d;
        end
        if (p == mbrpt_pkg::SECTOR_BYTES - 1) begin
          sig = (sig_low == mbrpt_pkg::SIG_LOW_BYTE) && (d == mbrpt_pkg::SIG_HIGH_BYTE);
          marked = 1'b0;
          used = 0;
          for (int i = 0; i < 4; i++) begin
            if (slot_status[i] != 8'h00 || slot_type[i] != mbrpt_pkg::TYPE_EMPTY)
              marked = 1'b1;
            if (sig && slot_type[i] != mbrpt_pkg::TYPE_EMPTY) begin
              used++;
              if (!typed_sector)
                expect_result(entry_result(i, slot_type[i],
                                           slot_status[i] == mbrpt_pkg::STATUS_BOOT,
                                           fs_of_type(slot_type[i]),
                                           slot_lba[i], slot_len[i]));
            end
          end
          if (!typed_sector) expect_result(summary_result(sig, marked, used));
          results_predicted += used + 1;
        end
      end
    end
  endtask

  // One byte transfer on the input channel, after a random gap.
  task automatic send_byte(input logic [7:0] d, input logic s);
    int idle;
    begin
      idle = gap_len();
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data_byte <= d;
      in_sector_start <= s;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      track_byte(d, s);
    end
  endtask

  task automatic send_sector(input sector_plan_t p);
    logic [7:0] b;
    int slot;
    int fld;
    begin
      steady = ($urandom_range(0, 3) == 0);
      // Junk bytes of a sector that gets cut short by a new sector start.
      for (int k = 0; k < p.restart; k++) send_byte(8'($urandom), k == 0);
      typed_sector = p.hand_checked;
      for (int pos = 0; pos < mbrpt_pkg::SECTOR_BYTES; pos++) begin
        b = 8'($urandom);
        if (pos >= mbrpt_pkg::TABLE_BASE &&
            pos < mbrpt_pkg::TABLE_BASE + mbrpt_pkg::TABLE_SLOTS * mbrpt_pkg::SLOT_BYTES) begin
          slot = (pos - mbrpt_pkg::TABLE_BASE) / mbrpt_pkg::SLOT_BYTES;
          fld = (pos - mbrpt_pkg::TABLE_BASE) % mbrpt_pkg::SLOT_BYTES;
          if (fld == 0) b = p.st[8*slot +: 8];
          else if (fld == 4) b = p.ty[8*slot +: 8];
          else if (fld >= 8 && fld < 12) b = p.lba[32*slot + 8*(fld-8) +: 8];
          else if (fld >= 12) b = p.cnt[32*slot + 8*(fld-12) +: 8];
        end else if (pos == mbrpt_pkg::SECTOR_BYTES - 2) begin
          b = p.lo;
        end else if (pos == mbrpt_pkg::SECTOR_BYTES - 1) begin
          b = p.hi;
        end
        send_byte(b, pos == 0 && (p.lead || p.restart > 0));
      end
      if (p.hand_checked) begin
        for (int i = 0; i < p.exp_used; i++)
          expect_result(entry_result(i, p.ty[8*i +: 8], p.exp_boot, p.exp_cls,
                                     p.lba[32*i +: 32], p.cnt[32*i +: 32]));
        expect_result(summary_result(p.exp_sig, p.exp_marked, p.exp_used));
      end
      typed_sector = 1'b0;
      // Trailing bytes past the end of the sector are ignored by the block.
      for (int k = 0; k < p.extra; k++) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer with the oldest expected result.
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("is_summary", want.is_summary, out_is_summary);
        check_field("slot_index", want.slot, out_slot_index);
        check_field("part_type", want.ptype, out_part_type);
        check_field("bootable", want.boot, out_bootable);
        check_field("fs_class", want.cls, out_fs_class);
        check_field("start_lba", want.lba, out_start_lba);
        check_field("sector_count", want.cnt, out_sector_count);
        check_field("signature_ok", want.sig, out_signature_ok);
        check_field("any_entry_marked", want.marked, out_any_entry_marked);
        check_field("used_entries", want.used, out_used_entries);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Receiver: runs of ready and stall, mostly short, some long.
  initial begin
    int len;
    int r;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        out_ready <= 1'b1;
        len = $urandom_range(1, 4);
      end else if (r < 8) begin
        out_ready <= 1'b0;
        len = $urandom_range(1, 3);
      end else if (r == 8) begin
        out_ready <= 1'b0;
        len = $urandom_range(10, 30);
      end else begin
        out_ready <= 1'b1;
        len = $urandom_range(20, 60);
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_sector_start = 1'b0;

    // Directed sectors.
    // First sector straight after reset, no sector start flag, empty table.
    add_plan(plan(1'b0, 32'h0, 32'h0, '0, '0,
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b1, 1'b1, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Empty table with a blank signature.
    add_plan(plan(1'b1, 32'h0, 32'h0, '0, '0, 8'h00, 8'h00,
                  0, 0, 1'b1, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Every stored table field at its maximum.
    add_plan(plan(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {128{1'b1}}, {128{1'b1}},
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b1, 1'b1, 1'b1, 4, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // One slot of each known type, mixed status, byte order visible in lba.
    add_plan(plan(1'b1, 32'h7F80_0080, 32'hEF83_0C0B,
                  {32'hFFFF_FFFE, 32'h8000_0000, 32'h0000_0001, 32'h0403_0201},
                  {32'h0000_0800, 32'h1122_3344, 32'h0000_0000, 32'h0D0C_0B0A},
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Two bootable EFI slots at sector zero, the upper slots empty.
    add_plan(plan(1'b1, 32'h0000_8080, 32'h0000_EFEF, '0,
                  {64'h0, 32'h0000_0001, 32'h0000_0001},
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b1, 1'b1, 1'b1, 2, 1'b1, mbrpt_pkg::FS_EFI));
    // Some status bytes set but every type empty.
    add_plan(plan(1'b1, 32'h0001_0080, 32'h0, {4{32'h1234_5678}}, {4{32'h9ABC_DEF0}},
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Marked slots behind each kind of broken signature.
    add_plan(plan(1'b1, 32'h0000_0080, 32'h8383_8383, '0, '0,
                  mbrpt_pkg::SIG_LOW_BYTE, 8'hAB,
                  0, 0, 1'b1, 1'b0, 1'b1, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    add_plan(plan(1'b1, 32'h0, 32'h0C00_0000, '0, '0,
                  8'h54, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b1, 1'b0, 1'b1, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    add_plan(plan(1'b1, 32'h8000_0000, 32'h0, '0, '0,
                  mbrpt_pkg::SIG_HIGH_BYTE, mbrpt_pkg::SIG_LOW_BYTE,
                  0, 0, 1'b1, 1'b0, 1'b1, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Holes in the table, status one above the boot flag.
    add_plan(plan(1'b1, 32'h8000_8081, 32'h0C00_8300,
                  {32'hAAAA_5555, 32'h0, 32'h0000_FFFF, 32'h7FFF_FFFF},
                  {32'h5555_AAAA, 32'h1, 32'hFFFF_0000, 32'h8000_0001},
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Restart in the middle of the table: the junk entries must be replaced.
    add_plan(plan(1'b1, 32'h0080_0080, 32'h0B83_EF0C,
                  {32'h4, 32'h3, 32'h2, 32'h1}, {32'h8, 32'h7, 32'h6, 32'h5},
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  470, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Restart right after byte 0, then bytes past the end of the sector.
    add_plan(plan(1'b1, 32'h0000_0080, 32'h0000_0083, {4{32'hCAFE_F00D}},
                  {4{32'h0BAD_BEEF}}, mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  1, 6, 1'b0, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // No sector start after a finished sector: the whole sector is ignored.
    add_plan(plan(1'b0, 32'h8080_8080, 32'h8383_8383, '0, '0,
                  mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, mbrpt_pkg::FS_UNKNOWN));
    // Restart one byte before the signature would complete.
    add_plan(plan(1'b1, 32'h0080_0000, 32'h00EF_0B00, {4{32'h0102_0304}},
                  {4{32'h0506_0708}}, mbrpt_pkg::SIG_LOW_BYTE, mbrpt_pkg::SIG_HIGH_BYTE,
                  mbrpt_pkg::SECTOR_BYTES - 1, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0,
                  mbrpt_pkg::FS_UNKNOWN));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plans[i]) send_sector(directed_plans[i]);

    // Random sectors until a few dozen results have been produced.
    while (results_predicted < 60) send_sector(random_plan());

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
